/* src/kvs_pkg.sv */
// Package for the keyframe vector sampler: widths, field types, controller
// command/status structs and the one-hot state encoding.
// No dependencies.
package kvs_pkg;

	localparam int DEFAULT_MAX_KEYS = 64;
	localparam int VAL_W = 32;
	localparam int KEY_IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int CFG_AW = 3;

	localparam logic [CFG_AW-1:0] REG_LOOP_ENABLE = 3'd0;
	localparam logic [CFG_AW-1:0] REG_KEY_COUNT = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// selects which record a table read fetches
	typedef enum logic [1:0] {
		RD_FIRST = 2'd0,
		RD_LAST = 2'd1,
		RD_SCAN = 2'd2,
		RD_PREV = 2'd3
	} rd_sel_t;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_RD_LAST = 14'b00000000000010,
		ST_RD_FIRST = 14'b00000000000100,
		ST_CHK_LAST = 14'b00000000001000,
		ST_MOD = 14'b00000000010000,
		ST_SCAN_RD = 14'b00000000100000,
		ST_SCAN_CHK = 14'b00000001000000,
		ST_PREV_RD = 14'b00000010000000,
		ST_PREV_CHK = 14'b00000100000000,
		ST_DIV = 14'b00001000000000,
		ST_MUL = 14'b00010000000000,
		ST_ADD = 14'b00100000000000,
		ST_KEY_OUT = 14'b01000000000000,
		ST_OUT = 14'b10000000000000
	} state_t;

	typedef struct packed {
		logic load_time;
		logic rd_en;
		rd_sel_t rd_sel;
		logic latch_first;
		logic latch_last;
		logic latch_cur;
		logic latch_prev;
		logic idx_inc;
		logic mod_start;
		logic load_rem;
		logic div_start;
		logic mul_en;
		logic add_en;
		logic res_load;
		logic key_from_cur;
	} cmd_t;

	typedef struct packed {
		logic t_gt_last;
		logic last_le_first;
		logic one_key;
		logic t_lt_cur;
		logic idx_at_last;
		logic idx_zero;
		logic cur_le_prev;
		logic div_busy;
	} sts_t;

endpackage

/* src/kvs_ram.sv */
// Generic single-port-write RAM with registered read.
// No dependencies.
module kvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/kvs_divider.sv */
// Restoring serial divider, one quotient bit a cycle; used for the time wrap
// (remainder) and the blend factor (quotient). Depends on kvs_pkg.
module kvs_divider
	import kvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [2*VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic busy,
	output logic [2*VAL_W-1:0] quotient,
	output logic [VAL_W-1:0] remainder
);
	localparam int CW = $clog2(2 * VAL_W + 1);

	logic [CW-1:0] cnt_q;
	logic [VAL_W:0] rem_q;
	logic [2*VAL_W-1:0] quo_q;
	logic [VAL_W-1:0] dvs_q;
	logic [VAL_W:0] trial;
	logic [VAL_W:0] diff;

	assign trial = {rem_q[VAL_W-1:0], quo_q[2*VAL_W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(2 * VAL_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[VAL_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[2*VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[2*VAL_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
	assign remainder = rem_q[VAL_W-1:0];
endmodule

/* src/kvs_datapath.sv */
// Datapath: key table, search index, divider, blend multiply/add and the
// output register. Depends on kvs_pkg, kvs_ram, kvs_divider.
module kvs_datapath
	import kvs_pkg::*;
#(
	parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [KEY_IDX_W-1:0] wr_idx,
	input  logic [VAL_W-1:0] in_time,
	input  logic [VAL_W-1:0] in_x,
	input  logic [VAL_W-1:0] in_y,
	input  logic [VAL_W-1:0] in_z,
	input  logic [CNT_W-1:0] key_count,
	input  cmd_t cmd,
	output sts_t sts,
	output logic [3*VAL_W-1:0] result
);
	localparam int AW = $clog2(MAX_KEYS);
	localparam int IW = AW + 1;
	localparam int RW = 4 * VAL_W;

	logic [RW-1:0] rd_data;
	logic [VAL_W-1:0] rd_time;
	logic [AW-1:0] raddr;
	logic [IW-1:0] n_eff;
	logic [IW-1:0] last_idx;
	logic [IW-1:0] idx_q;
	logic wr_ok;
	logic [VAL_W-1:0] t_q, tfirst_q, tcur_q;
	logic [3*VAL_W-1:0] vlast_q, vcur_q, vprev_q, res_q;
	logic [2*VAL_W-1:0] quo;
	logic [VAL_W-1:0] rem;
	logic [VAL_W-1:0] div_dvs;
	logic [2*VAL_W-1:0] div_dvd;
	logic [VAL_W-1:0] span, dt_raw, dt;
	logic div_busy;
	logic [16:0] f;
	logic signed [VAL_W+16:0] prod_s [3];
	logic signed [VAL_W+16:0] prod_q [3];
	logic [3*VAL_W-1:0] sum;
	logic unused;

	// clamp the key count to 1..MAX_KEYS
	always_comb begin
		if (key_count == '0) begin
			n_eff = IW'(1);
		end else if (32'(key_count) > 32'(MAX_KEYS)) begin
			n_eff = IW'(MAX_KEYS);
		end else begin
			n_eff = IW'(key_count);
		end
	end
	assign last_idx = n_eff - IW'(1);
	assign wr_ok = 32'(wr_idx) < 32'(MAX_KEYS);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_FIRST: raddr = '0;
			RD_LAST: raddr = last_idx[AW-1:0];
			RD_SCAN: raddr = idx_q[AW-1:0];
			RD_PREV: raddr = idx_q[AW-1:0] - AW'(1);
		endcase
	end

	kvs_ram #(.WIDTH(RW), .DEPTH(MAX_KEYS)) u_ram (
		.clk(clk),
		.we(wr_en && wr_ok),
		.waddr(AW'(wr_idx)),
		.wdata({in_z, in_y, in_x, in_time}),
		.re(cmd.rd_en),
		.raddr(raddr),
		.rdata(rd_data)
	);

	assign rd_time = rd_data[VAL_W-1:0];

	// the earlier key is on the read port in the cycle that starts the factor division
	assign span = tcur_q - rd_time;
	assign dt_raw = t_q - rd_time;
	assign dt = (dt_raw > span) ? span : dt_raw;
	// the wrap divisor takes the last key straight from the read port
	assign div_dvd = cmd.mod_start ? {{VAL_W{1'b0}}, t_q} : {16'd0, dt, 16'd0};
	assign div_dvs = cmd.mod_start ? rd_time - tfirst_q : span;

	kvs_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mod_start || cmd.div_start),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.busy(div_busy),
		.quotient(quo),
		.remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load_time) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_time) begin
			t_q <= in_time;
		end else if (cmd.load_rem) begin
			t_q <= rem;
		end
		if (cmd.latch_first) begin
			tfirst_q <= rd_time;
		end
		if (cmd.latch_last) begin
			vlast_q <= rd_data[RW-1:VAL_W];
		end
		if (cmd.latch_cur) begin
			tcur_q <= rd_time;
			vcur_q <= rd_data[RW-1:VAL_W];
		end
		if (cmd.latch_prev) begin
			vprev_q <= rd_data[RW-1:VAL_W];
		end
	end

	// blend: a + floor((b - a) * f / 65536), f in 0..65536
	assign f = quo[16:0];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (cmd.mul_en) begin
				prod_q[c] <= prod_s[c];
			end
		end
		if (cmd.add_en) begin
			res_q <= sum;
		end else if (cmd.res_load) begin
			res_q <= cmd.key_from_cur ? vcur_q : vlast_q;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod_s[c] = ($signed({vcur_q[c*VAL_W+VAL_W-1], vcur_q[c*VAL_W +: VAL_W]})
				- $signed({vprev_q[c*VAL_W+VAL_W-1], vprev_q[c*VAL_W +: VAL_W]}))
				* $signed({1'b0, f});
			sum[c*VAL_W +: VAL_W] = vprev_q[c*VAL_W +: VAL_W]
				+ VAL_W'(prod_q[c] >>> 16);
		end
	end

	assign sts.t_gt_last = rd_time < t_q;
	assign sts.last_le_first = rd_time <= tfirst_q;
	assign sts.one_key = (n_eff == IW'(1));
	assign sts.t_lt_cur = t_q < rd_time;
	assign sts.idx_at_last = (idx_q == last_idx);
	assign sts.idx_zero = (idx_q == '0);
	assign sts.cur_le_prev = tcur_q <= rd_time;
	assign sts.div_busy = div_busy;
	assign result = res_q;

	assign unused = ^{quo[2*VAL_W-1:17]};
endmodule

/* src/keyframe_vector_sampler_unit.sv */
// Keyframe vector sampler top level: stream ports, APB registers, controller FSM.
// A write is taken at its accept edge. A sample answers with the last key, with a scanned key
// after the key search, or with a blended value after the search and the factor division;
// a wrap adds a remainder division before the search.
// One item in flight: the next item is taken from the cycle after the result leaves.
// Reset (arst_n, asynchronous): loop_enable 0, key_count 1; key table undefined.
module keyframe_vector_sampler_unit
	import kvs_pkg::*;
#(
	parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// operation[0], key_index[6:1], item_time[38:7], value_x[70:39],
	// value_y[102:71], value_z[134:103], zero pad to 136
	input  logic [135:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [95:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic loop_q;
	logic [CNT_W-1:0] count_q;
	state_t state_q;
	cmd_t cmd;
	sts_t sts;
	logic acc;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
			count_q <= CNT_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				REG_LOOP_ENABLE: loop_q <= pwdata[0];
				REG_KEY_COUNT: count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr)
			REG_LOOP_ENABLE: prdata = {31'd0, loop_q};
			REG_KEY_COUNT: prdata = {25'd0, count_q};
			default: prdata = '0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);

	kvs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(acc && s_tdata[0] == OP_SAMPLE),
		.loop_en(loop_q),
		.out_taken(m_tready),
		.sts(sts),
		.cmd(cmd),
		.state(state_q)
	);

	kvs_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(acc && s_tdata[0] == OP_WRITE),
		.wr_idx(s_tdata[6:1]),
		.in_time(s_tdata[38:7]),
		.in_x(s_tdata[70:39]),
		.in_y(s_tdata[102:71]),
		.in_z(s_tdata[134:103]),
		.key_count(count_q),
		.cmd(cmd),
		.sts(sts),
		.result(m_tdata)
	);

	logic unused;
	assign unused = s_tdata[135];
endmodule

// Controller: sequences table reads, the time wrap, the key search and the blend.
module kvs_ctrl
	import kvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic loop_en,
	input  logic out_taken,
	input  sts_t sts,
	output cmd_t cmd,
	output state_t state
);
	state_t state_q, state_d;
	logic from_cur_q, from_cur_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			from_cur_q <= 1'b0;
		end else begin
			state_q <= state_d;
			from_cur_q <= from_cur_d;
		end
	end

	always_comb begin
		state_d = state_q;
		from_cur_d = from_cur_q;
		cmd = '0;
		cmd.rd_sel = RD_FIRST;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_time = 1'b1;
					state_d = ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_FIRST;
				state_d = ST_RD_LAST;
			end
			ST_RD_LAST: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_LAST;
				cmd.latch_first = 1'b1;
				state_d = ST_CHK_LAST;
			end
			ST_CHK_LAST: begin
				// last key is on the read port here
				cmd.latch_last = 1'b1;
				if (sts.t_gt_last && (!loop_en || sts.last_le_first)) begin
					from_cur_d = 1'b0;
					state_d = ST_KEY_OUT;
				end else if (sts.t_gt_last) begin
					cmd.mod_start = 1'b1;
					state_d = ST_MOD;
				end else if (sts.one_key) begin
					from_cur_d = 1'b0;
					state_d = ST_KEY_OUT;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_MOD: begin
				// hold until the remainder settles, then search with the wrapped time
				if (!sts.div_busy) begin
					cmd.load_rem = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_SCAN;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				cmd.latch_cur = 1'b1;
				if (sts.t_lt_cur || sts.idx_at_last) begin
					if (sts.idx_zero) begin
						from_cur_d = 1'b1;
						state_d = ST_KEY_OUT;
					end else begin
						state_d = ST_PREV_RD;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_PREV_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RD_PREV;
				state_d = ST_PREV_CHK;
			end
			ST_PREV_CHK: begin
				cmd.latch_prev = 1'b1;
				if (sts.cur_le_prev) begin
					from_cur_d = 1'b1;
					state_d = ST_KEY_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_en = 1'b1;
				state_d = ST_OUT;
			end
			ST_KEY_OUT: begin
				cmd.res_load = 1'b1;
				cmd.key_from_cur = from_cur_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_taken) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign state = state_q;
endmodule

/* dv/keyframe_vector_sampler_unit_tb.sv */
// Testbench for keyframe_vector_sampler_unit: random keyframe tables and sample
// times, checked against an in-bench interpolation predictor.
// Depends on kvs_pkg and the unit RTL.
module keyframe_vector_sampler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kvs_pkg::*;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vec_t;

	class track_scoreboard;
		logic [31:0] ktime [64];
		vec_t kvec [64];
		logic loop_en;
		logic [6:0] count;
		vec_t samples_due[$];
		int mismatches;

		function void reset_state();
			loop_en = 0;
			count = 1;
			for (int k = 0; k < 64; k++) begin
				ktime[k] = '0;
				kvec[k] = '0;
			end
		endfunction

		function logic [31:0] mix(logic [31:0] a, logic [31:0] b, logic [16:0] f);
			longint sa, prod;
			sa = longint'(signed'(a));
			prod = (longint'(signed'(b)) - sa) * longint'(f);
			// arithmetic shift floors toward minus infinity
			return 32'(sa + (prod >>> 16));
		endfunction

		function vec_t sample_vec(logic [31:0] qt);
			int n, last, i;
			logic [31:0] t, a, b, span, dt;
			logic [16:0] f;
			vec_t v;
			n = count == 0 ? 1 : (count > 64 ? 64 : count);
			last = n - 1;
			t = qt;
			if (ktime[last] < t) begin
				if (!loop_en || ktime[last] <= ktime[0]) return kvec[last];
				t = t % (ktime[last] - ktime[0]);
			end
			if (n == 1) return kvec[last];
			for (i = 0; i < n; i++)
				if (t < ktime[i]) break;
			if (i == n) i = last;
			if (i == 0) return kvec[0];
			a = ktime[i-1];
			b = ktime[i];
			if (b <= a) return kvec[i];
			span = b - a;
			dt = t - a;
			if (dt > span) dt = span;
			f = 17'(({32'd0, dt} << 16) / {32'd0, span});
			v.x = mix(kvec[i-1].x, kvec[i].x, f);
			v.y = mix(kvec[i-1].y, kvec[i].y, f);
			v.z = mix(kvec[i-1].z, kvec[i].z, f);
			return v;
		endfunction

		function void note_item(logic op, logic [5:0] idx, logic [31:0] t, vec_t v);
			if (op == OP_WRITE) begin
				ktime[idx] = t;
				kvec[idx] = v;
			end else samples_due.push_back(sample_vec(t));
		endfunction

		function void check_result(logic [95:0] d);
			vec_t want;
			logic [31:0] gx, gy, gz;
			gx = d[31:0];
			gy = d[63:32];
			gz = d[95:64];
			if (samples_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", d);
				return;
			end
			want = samples_due.pop_front();
			if (gx !== want.x || gy !== want.y || gz !== want.z) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp %h %h %h got %h %h %h",
						want.x, want.y, want.z, gx, gy, gz);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [135:0] s_tdata;
	logic [95:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	track_scoreboard track;
	int hold_off;
	logic [31:0] tb_times [64];
	int n_used;

	keyframe_vector_sampler_unit DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("keyframe_vector_sampler_unit_tb failed");
		$finish;
	end

	function int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		return $urandom_range(0, 19) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 3);
	endfunction

	task automatic reg_write(logic [CFG_AW-1:0] addr, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == REG_LOOP_ENABLE) track.loop_en = val[0];
		else track.count = val[6:0];
		@(posedge clk);
	endtask

	task automatic send_item(logic op, logic [5:0] idx, logic [31:0] t, vec_t v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {1'b0, v.z, v.y, v.x, t, idx, op};
		do @(posedge clk); while (!s_tready);
		track.note_item(op, idx, t, v);
	endtask

	function vec_t rnd_vec();
		vec_t v;
		case ($urandom_range(0, 4))
			0: v = {32'h8000_0000, 32'h7fff_ffff, 32'h0};
			1: v = {32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
			default: v = {$urandom(), $urandom(), $urandom()};
		endcase
		return v;
	endfunction

	// write n ascending (sometimes repeated) keys to slots 0..n-1
	task automatic load_table(int n, bit ties);
		logic [31:0] t;
		t = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32'h40000);
		for (int k = 0; k < n; k++) begin
			tb_times[k] = t;
			send_item(OP_WRITE, 6'(k), t, rnd_vec());
			if (!(ties && $urandom_range(0, 2) == 0))
				t = t + ($urandom_range(0, 9) == 0 ? $urandom() >> 2 : $urandom_range(1, 32'h30000));
		end
	endtask

	function logic [31:0] rnd_time();
		case ($urandom_range(0, 6))
			0: return 0;
			1: return 32'hffff_ffff;
			2: return tb_times[$urandom_range(0, n_used - 1)];
			3: return $urandom();
			default: return $urandom_range(tb_times[0], tb_times[n_used-1] + 32'h10000);
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 0;
		while (track.samples_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic phase(int n, bit lp, bit ties, int samples);
		drain();
		reg_write(REG_KEY_COUNT, 32'(n));
		reg_write(REG_LOOP_ENABLE, 32'(lp));
		n_used = n;
		load_table(n, ties);
		for (int k = 0; k < samples; k++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(OP_WRITE, 6'($urandom_range(0, 63)),
					$urandom(), rnd_vec()) ;
			else send_item(OP_SAMPLE, 6'($urandom()), rnd_time(), rnd_vec());
			// rewrite of an in-use slot may break ordering; refresh the time list
			for (int j = 0; j < n_used; j++) tb_times[j] = track.ktime[j];
		end
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) track.check_result(m_tdata);
	end

	initial begin
		int stall;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				m_tready <= 0;
				hold_off--;
			end else if (stall > 0) begin
				m_tready <= 0;
				stall--;
			end else begin
				m_tready <= 1;
				if ($urandom_range(0, 5) == 0) stall = pick_gap();
			end
		end
	end

	initial begin
		int wait_cnt;
		track = new();
		track.reset_state();
		s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		hold_off = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// single key, then extremes, then ties and loops
		n_used = 1;
		send_item(OP_WRITE, 6'd0, 32'h1_0000, {32'h7fff_ffff, 32'h8000_0000, 32'h1});
		send_item(OP_SAMPLE, 6'h3f, 32'h0, '1);
		send_item(OP_SAMPLE, 6'd0, 32'hffff_ffff, '0);
		phase(2, 1'b1, 1'b0, 8);
		phase(64, 1'b0, 1'b0, 8);
		phase(64, 1'b1, 1'b1, 8);
		// long receiver stall, set just before the drain and table load
		hold_off = 1000;
		phase(3, 1'b1, 1'b0, 8);
		for (int p = 0; p < 36; p++) begin
			int n;
			n = $urandom_range(0, 7) == 0 ? $urandom_range(33, 64) : $urandom_range(1, 8);
			phase(n, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0, 35);
		end
		s_tvalid <= 0;
		wait_cnt = 0;
		while (track.samples_due.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (300) @(posedge clk);
		if (track.mismatches == 0 && track.samples_due.size() == 0)
			$display("keyframe_vector_sampler_unit_tb passed");
		else
			$display("keyframe_vector_sampler_unit_tb failed");
		$finish;
	end
endmodule
